// ===== sv/kms_pkg.sv =====
`timescale 1ns / 1ps

package kms_pkg;

  // Default matrix geometry
  localparam int unsigned ROWS_DEF = 5;
  localparam int unsigned COLS_DEF = 4;

  // Fixed field widths
  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned COL_IN_W    = 4;
  localparam int unsigned KEY_W       = 5;
  localparam int unsigned ROW_DRIVE_W = 5;
  localparam int unsigned KEY_BITS_W  = 20;
  localparam int unsigned DEBOUNCE_W  = 10;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(100);

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK = 2'd0,
    ACT_SCAN = 2'd1,
    ACT_POLL = 2'd2
  } action_e;

  typedef struct packed {
    action_e             action;
    logic [COL_IN_W-1:0] column_bits;
    logic [KEY_W-1:0]    first_key;
    logic [KEY_W-1:0]    last_key;
  } in_item_t;

  typedef struct packed {
    logic [ROW_DRIVE_W-1:0] row_drive;
    logic [KEY_BITS_W-1:0]  key_bits;
    logic                   pressed_found;
    logic [KEY_W-1:0]       pressed_key;
    logic                   click_found;
    logic [KEY_W-1:0]       click_key;
  } out_item_t;

endpackage

// ===== sv/kms_core.sv =====
`timescale 1ns / 1ps

module kms_core #(
  parameter int unsigned ROWS = kms_pkg::ROWS_DEF,
  parameter int unsigned COLS = kms_pkg::COLS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  kms_pkg::in_item_t                   item_i,
  input  logic                                cfg_we_i,
  input  logic [kms_pkg::DEBOUNCE_W-1:0]      cfg_wdata_i,
  output kms_pkg::out_item_t                  res_o
);
  import kms_pkg::*;

  localparam int unsigned NKEYS = ROWS * COLS;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  logic [DEBOUNCE_W-1:0] debounce_q;
  logic [ROW_W-1:0]      scan_row_q, scan_row_d;
  logic [NKEYS-1:0]      key_down_q, key_down_d;
  logic [DEBOUNCE_W-1:0] lock_q [NKEYS];
  logic [DEBOUNCE_W-1:0] lock_d [NKEYS];

  logic             poll_found;
  logic [KEY_W-1:0] poll_key;

  // Next state
  always_comb begin
    int unsigned idx;
    scan_row_d = scan_row_q;
    key_down_d = key_down_q;
    lock_d     = lock_q;
    poll_found = 1'b0;
    poll_key   = '0;
    idx        = 0;
    unique case (item_i.action)
      ACT_TICK: begin
        for (int k = 0; k < NKEYS; k++) begin
          if (lock_q[k] != '0) lock_d[k] = lock_q[k] - DEBOUNCE_W'(1);
        end
      end
      ACT_SCAN: begin
        for (int c = 0; c < COLS; c++) begin
          idx = c * ROWS + int'(scan_row_q);
          key_down_d[idx] = (c < COL_IN_W) ? item_i.column_bits[c % COL_IN_W] : 1'b0;
        end
        scan_row_d = (scan_row_q == ROW_LAST) ? '0 : scan_row_q + ROW_W'(1);
      end
      ACT_POLL: begin
        // Walk the range; reload every pressed key up to and including the click
        for (int k = 0; k < NKEYS; k++) begin
          if (!poll_found && key_down_q[k] && (k >= int'(item_i.first_key))
              && (k <= int'(item_i.last_key))) begin
            lock_d[k] = debounce_q;
            if (lock_q[k] == '0) begin
              poll_found = 1'b1;
              poll_key   = KEY_W'(k);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result from the updated state
  always_comb begin
    res_o = '0;
    for (int r = 0; r < ROW_DRIVE_W; r++) begin
      res_o.row_drive[r] = (int'(scan_row_d) == r);
    end
    for (int k = 0; k < KEY_BITS_W; k++) begin
      if (k < NKEYS) res_o.key_bits[k] = key_down_d[k % NKEYS];
    end
    // Scan downward so the lowest pressed key wins
    for (int k = NKEYS - 1; k >= 0; k--) begin
      if (key_down_d[k]) begin
        res_o.pressed_found = 1'b1;
        res_o.pressed_key   = KEY_W'(k);
      end
    end
    res_o.click_found = poll_found;
    res_o.click_key   = poll_key;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
    end else if (cfg_we_i) begin
      debounce_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_row_q <= '0;
      key_down_q <= '0;
      for (int k = 0; k < NKEYS; k++) lock_q[k] <= '0;
    end else if (accept_i) begin
      scan_row_q <= scan_row_d;
      key_down_q <= key_down_d;
      lock_q     <= lock_d;
    end
  end

endmodule

// ===== sv/keypad_matrix_scan_click_detect.sv =====
`timescale 1ns / 1ps

// Key matrix scanner with click detection. Every transaction (millisecond
// tick, scan step or click poll) updates the key state at the edge it is
// accepted; its result is registered at that edge into the output register,
// or into the second entry while the output is held. A two-entry output
// buffer lets a new transaction enter while the previous result waits: one
// transaction per cycle unless in_stall_o, high only while both entries hold.
module keypad_matrix_scan_click_detect #(
  parameter int unsigned ROWS = kms_pkg::ROWS_DEF,
  parameter int unsigned COLS = kms_pkg::COLS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  kms_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output kms_pkg::out_item_t             out_data_o,
  input  logic                           cfg_we_i,
  input  logic [kms_pkg::DEBOUNCE_W-1:0] cfg_wdata_i
);
  import kms_pkg::*;

  logic      accept;
  logic      out_take;
  out_item_t res;
  logic      out_valid_q;
  logic      skid_valid_q;
  out_item_t out_q;
  out_item_t skid_q;

  assign accept     = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;
  assign in_stall_o = skid_valid_q;

  kms_core #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= accept;
      end
    end else if (accept) begin
      // Output held: park the new result
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import kms_pkg::*;

  localparam int unsigned NUM_KEYS    = ROWS_DEF * COLS_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam action_e     ACT_UNUSED  = action_e'(2'd3);

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [DEBOUNCE_W-1:0] cfg_wdata = '0;

  // Model of the key state, kept in step with accepted transactions
  logic [NUM_KEYS-1:0]   keys_held;
  logic [DEBOUNCE_W-1:0] lockout_left [NUM_KEYS];
  logic [2:0]            scan_row_now;
  logic [DEBOUNCE_W-1:0] debounce_now;

  out_item_t status_due [$];
  out_item_t oldest_status;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_left = 0;
  int cycles = 0;
  int errors = 0;

  keypad_matrix_scan_click_detect uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, status_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: a long hold-off takes priority over random stalls
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  task automatic report_mismatch(input string what);
    $display("ERROR cycle %0d: %s", cycles, what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (status_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result 0x%0h", out_data));
      end else begin
        oldest_status = status_due.pop_front();
        check_field("row_drive", 32'(out_data.row_drive), 32'(oldest_status.row_drive));
        check_field("key_bits", 32'(out_data.key_bits), 32'(oldest_status.key_bits));
        check_field("pressed_found", 32'(out_data.pressed_found),
                    32'(oldest_status.pressed_found));
        check_field("pressed_key", 32'(out_data.pressed_key),
                    32'(oldest_status.pressed_key));
        check_field("click_found", 32'(out_data.click_found),
                    32'(oldest_status.click_found));
        check_field("click_key", 32'(out_data.click_key), 32'(oldest_status.click_key));
      end
    end
  end

  // Apply one transaction to the key state and return the status it reports
  function automatic out_item_t apply_key_action(input in_item_t item);
    out_item_t status;
    int        k;
    int        c;
    status = '0;
    case (item.action)
      ACT_TICK: begin
        for (k = 0; k < NUM_KEYS; k++)
          if (lockout_left[k] != 0) lockout_left[k] = lockout_left[k] - 1'b1;
      end
      ACT_SCAN: begin
        for (c = 0; c < COLS_DEF; c++)
          keys_held[c * ROWS_DEF + scan_row_now] = item.column_bits[c];
        scan_row_now = (scan_row_now == ROWS_DEF - 1) ? 3'd0 : scan_row_now + 3'd1;
      end
      ACT_POLL: begin
        // Walk the range; every pressed key reloads, the first unlocked one clicks
        for (k = int'(item.first_key); k <= int'(item.last_key); k++) begin
          if (k >= NUM_KEYS || !keys_held[k]) continue;
          if (lockout_left[k] == 0) begin
            lockout_left[k] = debounce_now;
            status.click_found = 1'b1;
            status.click_key = KEY_W'(k);
            break;
          end
          lockout_left[k] = debounce_now;
        end
      end
      default: ;
    endcase
    status.row_drive = ROW_DRIVE_W'(1 << scan_row_now);
    status.key_bits = keys_held;
    status.pressed_found = |keys_held;
    for (k = NUM_KEYS - 1; k >= 0; k--)
      if (keys_held[k]) status.pressed_key = KEY_W'(k);
    return status;
  endfunction

  function automatic in_item_t make_item(input action_e act, input logic [3:0] cols,
                                         input logic [4:0] first, input logic [4:0] last);
    in_item_t item;
    item.action = act;
    item.column_bits = cols;
    item.first_key = first;
    item.last_key = last;
    return item;
  endfunction

  function automatic in_item_t random_key_item();
    in_item_t item;
    int       pick;
    int       lo;
    pick = $urandom_range(99);
    item.column_bits = 4'($urandom_range(15));
    item.first_key = 5'($urandom_range(31));
    item.last_key = 5'($urandom_range(31));
    if (pick < 36) begin
      item.action = ACT_TICK;
    end else if (pick < 68) begin
      item.action = ACT_SCAN;
    end else if (pick < 96) begin
      item.action = ACT_POLL;
      // mostly a sensible range inside the matrix
      if ($urandom_range(9) < 7) begin
        lo = $urandom_range(NUM_KEYS - 1);
        item.first_key = 5'(lo);
        item.last_key = 5'($urandom_range(NUM_KEYS - 1, lo));
      end
    end else begin
      item.action = ACT_UNUSED;
    end
    return item;
  endfunction

  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    status_due.push_back(apply_key_action(item));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_debounce(input logic [DEBOUNCE_W-1:0] value);
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    debounce_now = value;
  endtask

  task automatic run_random(input int count);
    repeat (count) send_item(random_key_item());
  endtask

  task automatic test_directed();
    // status before any scan: row 0 driven, nothing pressed
    send_item(make_item(ACT_POLL, 4'h0, 5'd0, 5'd19));
    send_item(make_item(ACT_UNUSED, 4'hF, 5'd31, 5'd31));
    send_item(make_item(ACT_SCAN, 4'hF, 5'd0, 5'd0));
    send_item(make_item(ACT_SCAN, 4'h0, 5'd31, 5'd0));
    send_item(make_item(ACT_SCAN, 4'hA, 5'd0, 5'd0));
    send_item(make_item(ACT_SCAN, 4'h5, 5'd0, 5'd0));
    send_item(make_item(ACT_SCAN, 4'h8, 5'd0, 5'd0));
    send_item(make_item(ACT_POLL, 4'h0, 5'd19, 5'd0));
    send_item(make_item(ACT_POLL, 4'h0, 5'd20, 5'd31));
    send_item(make_item(ACT_POLL, 4'h0, 5'd0, 5'd19));
    send_item(make_item(ACT_POLL, 4'h0, 5'd0, 5'd19));
    send_item(make_item(ACT_POLL, 4'h0, 5'd0, 5'd0));
    send_item(make_item(ACT_TICK, 4'hF, 5'd31, 5'd31));
    send_item(make_item(ACT_POLL, 4'h0, 5'd19, 5'd31));
    send_item(make_item(ACT_POLL, 4'h0, 5'd31, 5'd31));
    send_item(make_item(ACT_SCAN, 4'h0, 5'd0, 5'd0));
    send_item(make_item(ACT_UNUSED, 4'h0, 5'd0, 5'd0));
  endtask

  task automatic test_zero_debounce();
    write_debounce('0);
    send_item(make_item(ACT_POLL, 4'h0, 5'd0, 5'd19));
    send_item(make_item(ACT_POLL, 4'h0, 5'd0, 5'd19));
    send_item(make_item(ACT_TICK, 4'h0, 5'd0, 5'd0));
    send_item(make_item(ACT_POLL, 4'h0, 5'd0, 5'd31));
  endtask

  task automatic test_streaming();
    write_debounce(10'd5);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    run_random(400);
  endtask

  task automatic test_sender_gaps();
    write_debounce(10'd1023);
    tx_idle_pct = 81;
    rx_stall_pct = 0;
    run_random(250);
  endtask

  task automatic test_receiver_stalls();
    write_debounce(10'd1);
    tx_idle_pct = 0;
    rx_stall_pct = 81;
    run_random(250);
  endtask

  task automatic test_both_sides_idle();
    write_debounce(10'd3);
    tx_idle_pct = 28;
    rx_stall_pct = 28;
    run_random(250);
  endtask

  task automatic test_backpressure();
    write_debounce(10'd100);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    // hold the output long enough for the block to fill and stall its input
    rx_hold_left = 300;
    run_random(150);
  endtask

  task automatic test_drain_pauses();
    int burst;
    write_debounce(10'd7);
    for (burst = 0; burst < 4; burst++) begin
      tx_idle_pct = (burst % 2 == 0) ? 0 : 28;
      rx_stall_pct = (burst < 2) ? 28 : 0;
      run_random(100);
      wait_drained();
    end
  endtask

  initial begin
    keys_held = '0;
    for (int k = 0; k < NUM_KEYS; k++) lockout_left[k] = '0;
    scan_row_now = '0;
    debounce_now = DEBOUNCE_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_zero_debounce();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_sides_idle();
    test_backpressure();
    test_drain_pauses();

    tx_idle_pct = 0;
    rx_stall_pct = 0;
    wait_drained();
    repeat (4) @(posedge clk);
    if (status_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", status_due.size()));
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/kms_pkg.sv
sv/kms_core.sv
sv/keypad_matrix_scan_click_detect.sv
bench/tb.sv
